// ===== rtl/core/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Types, codes and widths shared by the agent cycle sequencer.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int THR_WIDTH   = 8;
  localparam int OUT_CNT_W   = 8;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  localparam logic [THR_WIDTH-1:0]   THR_RESET = THR_WIDTH'(5);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_RESET      = 3'd1,
    ST_OBSERVE    = 3'd2,
    ST_ACT        = 3'd3,
    ST_SEND_STOPS = 3'd4,
    ST_SHUTDOWN   = 3'd5,
    ST_OVER       = 3'd6
  } state_t;

  typedef enum logic [2:0] {
    RQ_NONE  = 3'd0,
    RQ_OBS   = 3'd1,
    RQ_ACT   = 3'd2,
    RQ_START = 3'd3,
    RQ_STOP  = 3'd4,
    RQ_ERROR = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    OP_INTERRUPT = 2'd0,
    OP_BEGIN     = 2'd1,
    OP_END       = 2'd2,
    OP_INVALID   = 2'd3
  } op_t;

  typedef struct packed {
    logic [2:0]             state;
    logic                   req_write;
    logic [2:0]             req_value;
    logic [COUNT_WIDTH-1:0] count;
  } step_t;

endpackage

// ===== rtl/core/acs_step.sv =====
// ----------------------------------------------------------------------------
// acs_step
// Next-state, request overwrite and stop counter logic for one event.
// ----------------------------------------------------------------------------
module acs_step
  import acs_pkg::*;
(
  input  logic [2:0]             state,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [THR_WIDTH-1:0]   thr,
  input  logic [1:0]             op,
  input  logic [2:0]             req,
  output step_t                  res
);

  logic [CMP_WIDTH-1:0]   cnt_ext;
  logic [CMP_WIDTH-1:0]   inc_ext;
  logic [CMP_WIDTH-1:0]   thr_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   at_max;

  assign at_max  = (count == CNT_MAX);
  assign cnt_inc = at_max ? count : count + COUNT_WIDTH'(1);
  assign cnt_ext = CMP_WIDTH'(count);
  assign inc_ext = CMP_WIDTH'(cnt_inc);
  assign thr_ext = CMP_WIDTH'(thr);

  always_comb begin
    res.state     = state;
    res.req_write = 1'b0;
    res.req_value = RQ_NONE;
    res.count     = count;
    case (op_t'(op))
      OP_INTERRUPT: begin
        if (state != ST_SHUTDOWN) begin
          res.state     = ST_SHUTDOWN;
          res.req_write = 1'b1;
          res.count     = '0;
        end
      end
      OP_BEGIN: begin
        case (state)
          ST_IDLE: begin
            case (req)
              RQ_NONE: ;
              RQ_OBS:  res.state = ST_OBSERVE;
              RQ_ACT:  res.state = ST_ACT;
              RQ_START: begin
                res.req_write = 1'b1;
              end
              RQ_STOP: begin
                res.state     = ST_SEND_STOPS;
                res.req_write = 1'b1;
                res.count     = '0;
              end
              default: begin
                res.req_write = 1'b1;
                res.req_value = RQ_ERROR;
              end
            endcase
          end
          ST_SEND_STOPS: begin
            case (req)
              RQ_NONE: ;
              RQ_START: begin
                if (cnt_ext >= thr_ext) res.state = ST_RESET;
              end
              RQ_STOP: begin
                res.req_write = 1'b1;
                res.count     = '0;
              end
              default: begin
                res.req_write = 1'b1;
                res.req_value = RQ_ERROR;
              end
            endcase
          end
          ST_RESET, ST_OBSERVE, ST_ACT, ST_SHUTDOWN, ST_OVER: ;
          default: begin
            res.state     = ST_SHUTDOWN;
            res.req_write = 1'b1;
            res.count     = '0;
          end
        endcase
      end
      OP_END: begin
        case (state)
          ST_IDLE, ST_OVER: ;
          ST_RESET, ST_OBSERVE, ST_ACT: begin
            res.state     = ST_IDLE;
            res.req_write = 1'b1;
          end
          ST_SEND_STOPS: begin
            if (cnt_ext < thr_ext) res.count = cnt_inc;
          end
          ST_SHUTDOWN: begin
            res.count = cnt_inc;
            if (inc_ext >= thr_ext) res.state = ST_OVER;
          end
          default: begin
            res.state     = ST_SHUTDOWN;
            res.req_write = 1'b1;
            res.count     = '0;
          end
        endcase
      end
      default: begin
        res.state     = ST_SHUTDOWN;
        res.req_write = 1'b1;
        res.count     = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/agent_cycle_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// agent_cycle_sequencer_top
// Event-driven agent cycle sequencer with input and result registers.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | op, current_request
//  out     | out_valid/out_stall | new_state, request_write, request_value,
//          |                     | stop_count
//  cfg     | cfg_we              | cfg_wdata (stop cycles needed)
//
//  One item per clock sustained while out_stall is low; an accepted input
//  passes the input register, then next-state logic into the result register.
//  State and stop counter update as an item moves into the result register.
//  Synchronous reset: state send_stops, counter zero, threshold 5, both
//  registers empty. A stalled result holds and the input register keeps
//  accepting until it is full.
// ----------------------------------------------------------------------------
module agent_cycle_sequencer_top
  import acs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [2:0]           current_request,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           new_state,
  output logic                 request_write,
  output logic [2:0]           request_value,
  output logic [OUT_CNT_W-1:0] stop_count,
  input  logic                 cfg_we,
  input  logic [THR_WIDTH-1:0] cfg_wdata
);

  logic                   hold_valid;
  logic [1:0]             hold_op;
  logic [2:0]             hold_req;
  logic [THR_WIDTH-1:0]   thr;
  state_t                 state;
  logic [COUNT_WIDTH-1:0] count;
  step_t                  res;
  logic                   advance;
  logic                   out_free;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  acs_step u_step (
    .state (state),
    .count (count),
    .thr   (thr),
    .op    (hold_op),
    .req   (hold_req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_op  <= op;
      hold_req <= current_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SEND_STOPS;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_t'(res.state);
        count <= res.count;
      end
      if (out_free) begin
        out_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_state     <= res.state;
      request_write <= res.req_write;
      request_value <= res.req_value;
      stop_count    <= OUT_CNT_W'(CMP_WIDTH'(res.count));
    end
  end

  a_state_tracks_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_state == state)
    else $error("result state differs from state register");

  a_value_only_on_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request_write |-> request_value == RQ_NONE)
    else $error("request value set without write");

  a_over_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_state == ST_OVER |-> !request_write)
    else $error("request overwritten on entry to over");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled with room to advance");

endmodule
